>>> hdl/bba_pkg.sv
// Shared types, constants and state encoding for the blocked bitmap allocator.
package bba_pkg;

	localparam int SLOT_W         = 14;
	localparam int CFG_W          = 5;
	localparam int BLOCK_SIZE_DEF = 1024;
	localparam int MAX_BLOCKS_DEF = 16;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [SLOT_W-1:0] slot_number;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] granted_slot;
		logic              success;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_SET,
		ST_FREE
	} bba_state_t;

endpackage

>>> hdl/bba_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/blocked_bitmap_allocator_top.sv
// Top level of the blocked bitmap slot allocator with its map and summary memories.
//
//  channel   signals                      flow
//  request   start, busy, req             in,  taken when start is high and busy low
//  result    done, result                 out, one cycle per word, cannot be held off
//  config    cfg_valid, cfg_ready, cfg_data  in, taken when valid and ready are high
//
// A successful allocate holds busy while it examines blocks in turn and then sets the slot;
// a failed one holds it while it examines every block in use.
// A free in range holds busy for a read-modify-write of map and summary; one out of range
// is answered without raising busy. The result strobe is registered and rises in the cycle
// after the last busy cycle. After reset and after every configuration write a clearing pass
// over all MAX_BLOCKS * BLOCK_SIZE / WORD_W map words (256 by default) holds busy.
module blocked_bitmap_allocator_top
	import bba_pkg::*;
#(
	parameter int BLOCK_SIZE = BLOCK_SIZE_DEF,
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output res_t             result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int WORD_W = (BLOCK_SIZE % 64 == 0) ? 64 :
	                        (BLOCK_SIZE % 32 == 0) ? 32 :
	                        (BLOCK_SIZE % 16 == 0) ? 16 :
	                        (BLOCK_SIZE % 8 == 0)  ? 8  :
	                        (BLOCK_SIZE % 4 == 0)  ? 4  :
	                        (BLOCK_SIZE % 2 == 0)  ? 2  : 1;
	localparam int WB_W   = $clog2(WORD_W);
	localparam int BI_W   = (WB_W > 0) ? WB_W : 1;
	localparam int WPB    = BLOCK_SIZE / WORD_W;
	localparam int WO_W   = (WPB > 1) ? $clog2(WPB) : 1;
	localparam int WORDS  = MAX_BLOCKS * WPB;
	localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CL_W   = $clog2(WORDS + 1);
	localparam int BLK_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int NB_W   = $clog2(MAX_BLOCKS + 1);
	localparam int CNT_W  = (NB_W > CFG_W) ? NB_W : CFG_W;
	localparam int TOTAL  = MAX_BLOCKS * BLOCK_SIZE;
	localparam int LIM_W  = $clog2(TOTAL + 1);
	localparam int CMP_W  = (LIM_W > SLOT_W) ? LIM_W : SLOT_W + 1;
	localparam int SA_W   = WA_W + BI_W + 1;

	bba_state_t state_q, state_d;

	logic [CFG_W-1:0] cfg_q;
	logic [BLK_W-1:0] search_q;
	logic [CL_W-1:0]  clr_q;
	logic             done_q;
	res_t             res_q;

	logic [BLK_W-1:0]  blk_s1;
	logic [CNT_W-1:0]  lap_q;
	logic [WA_W-1:0]   word_s1;
	logic [WO_W-1:0]   widx_s1;
	logic [WPB-1:0]    sum_s1;
	logic [BI_W-1:0]   bit_s1;

	logic              cfg_wr;
	logic              accept;
	logic [CNT_W-1:0]  cfg_ext;
	logic [CNT_W-1:0]  nb;
	logic [BLK_W-1:0]  start_blk;
	logic [CNT_W-1:0]  blk_inc;
	logic [BLK_W-1:0]  blk_next;
	logic [CNT_W-1:0]  lap_inc;
	logic              scan_last;
	logic [CMP_W-1:0]  limit;
	logic [CMP_W-1:0]  slot_ext;
	logic              in_range;
	logic [MAX_BLOCKS-1:0] thermo;
	logic [BLK_W-1:0]  free_blk;
	logic [WA_W-1:0]   free_word;
	logic [BI_W-1:0]   free_bit;
	logic              clr_last;

	logic              bm_we;
	logic [WA_W-1:0]   bm_waddr;
	logic [WORD_W-1:0] bm_wdata;
	logic [WA_W-1:0]   bm_raddr;
	logic [WORD_W-1:0] bm_rdata;
	logic              sum_we;
	logic [BLK_W-1:0]  sum_waddr;
	logic [WPB-1:0]    sum_wdata;
	logic [BLK_W-1:0]  sum_raddr;
	logic [WPB-1:0]    sum_rdata;

	logic              sum_full;
	logic [WO_W-1:0]   scan_widx;
	logic [WA_W-1:0]   scan_word;
	logic [BI_W-1:0]   set_bit;
	logic [WORD_W-1:0] set_word;
	logic              set_full;
	logic [WO_W-1:0]   free_woff;
	logic [WORD_W-1:0] clr_word;
	logic [WPB-1:0]    clr_sum;
	logic [SA_W-1:0]   set_slot;

	logic              res_load;
	res_t              res_val;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start & ~busy;
	assign done      = done_q;
	assign result    = res_q;

	// Block count, with zero taken as one and large values clamped.
	assign cfg_ext = CNT_W'(cfg_q);
	assign nb = (cfg_ext == '0) ? CNT_W'(1) :
	            (cfg_ext > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_ext;

	assign start_blk = (CNT_W'(search_q) >= nb) ? '0 : search_q;
	assign blk_inc   = CNT_W'(blk_s1) + CNT_W'(1);
	assign blk_next  = (blk_inc >= nb) ? '0 : BLK_W'(blk_inc);
	assign lap_inc   = lap_q + CNT_W'(1);
	assign scan_last = (lap_inc == nb);

	assign limit    = CMP_W'(nb) * CMP_W'(BLOCK_SIZE);
	assign slot_ext = CMP_W'(req.slot_number);
	assign in_range = (slot_ext < limit);

	always_comb begin
		thermo = '0;
		for (int k = 1; k < MAX_BLOCKS; k++) begin
			thermo[k] = (slot_ext >= CMP_W'(k * BLOCK_SIZE));
		end
	end

	assign free_blk  = BLK_W'($countones(thermo));
	assign free_word = WA_W'(slot_ext / CMP_W'(WORD_W));
	assign free_bit  = BI_W'(slot_ext % CMP_W'(WORD_W));
	assign clr_last  = (clr_q == CL_W'(WORDS - 1));

	// Lowest word of the block that still has a free slot.
	always_comb begin
		scan_widx = '0;
		for (int i = WPB - 1; i >= 0; i--) begin
			if (!sum_rdata[i]) begin
				scan_widx = WO_W'(i);
			end
		end
	end

	// Lowest free slot of the word read from the map.
	always_comb begin
		set_bit = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!bm_rdata[i]) begin
				set_bit = BI_W'(i);
			end
		end
	end

	assign sum_full  = &sum_rdata;
	assign scan_word = WA_W'(blk_s1) * WA_W'(WPB) + WA_W'(scan_widx);
	assign set_word  = bm_rdata | (WORD_W'(1) << set_bit);
	assign set_full  = &set_word;
	assign set_slot  = SA_W'(word_s1) * SA_W'(WORD_W) + SA_W'(set_bit);
	assign free_woff = WO_W'(word_s1 - WA_W'(blk_s1) * WA_W'(WPB));
	assign clr_word  = bm_rdata & ~(WORD_W'(1) << bit_s1);
	assign clr_sum   = sum_rdata & ~(WPB'(1) << free_woff);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (req.kind == KIND_ALLOC) begin
						state_d = ST_SCAN;
					end else if (in_range) begin
						state_d = ST_FREE;
					end
				end
			end
			ST_SCAN: begin
				if (!sum_full) begin
					state_d = ST_SET;
				end else if (scan_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_SET:  state_d = ST_IDLE;
			ST_FREE: state_d = ST_IDLE;
			default: state_d = ST_CLEAR;
		endcase
		if (cfg_wr) begin
			state_d = ST_CLEAR;
		end
	end

	always_comb begin
		bm_we     = 1'b0;
		bm_waddr  = word_s1;
		bm_wdata  = set_word;
		bm_raddr  = free_word;
		sum_we    = 1'b0;
		sum_waddr = blk_s1;
		sum_wdata = sum_s1 | (WPB'(1) << widx_s1);
		sum_raddr = start_blk;
		res_load  = 1'b0;
		res_val   = '0;
		case (state_q)
			ST_CLEAR: begin
				bm_we     = 1'b1;
				bm_waddr  = clr_q[WA_W-1:0];
				bm_wdata  = '0;
				sum_we    = (clr_q < CL_W'(MAX_BLOCKS));
				sum_waddr = clr_q[BLK_W-1:0];
				sum_wdata = '0;
			end
			ST_IDLE: begin
				if (accept && req.kind == KIND_FREE) begin
					sum_raddr = free_blk;
					res_load  = ~in_range;
				end
			end
			ST_SCAN: begin
				if (sum_full) begin
					sum_raddr = blk_next;
					res_load  = scan_last;
				end else begin
					bm_raddr = scan_word;
				end
			end
			ST_SET: begin
				bm_we                = 1'b1;
				sum_we               = set_full;
				res_load             = 1'b1;
				res_val.granted_slot = SLOT_W'(set_slot);
				res_val.success      = 1'b1;
			end
			ST_FREE: begin
				bm_we           = 1'b1;
				bm_wdata        = clr_word;
				sum_we          = 1'b1;
				sum_wdata       = clr_sum;
				res_load        = 1'b1;
				res_val.success = 1'b1;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			cfg_q    <= CFG_RESET;
			search_q <= '0;
			clr_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_load;
			if (cfg_wr) begin
				cfg_q <= cfg_data;
				clr_q <= '0;
			end else if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CL_W'(1);
			end
			if (state_q == ST_CLEAR) begin
				search_q <= '0;
			end else if (state_q == ST_SET) begin
				search_q <= blk_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_val;
		end
		if (state_q == ST_IDLE && accept) begin
			blk_s1  <= (req.kind == KIND_ALLOC) ? start_blk : free_blk;
			lap_q   <= '0;
			word_s1 <= free_word;
			bit_s1  <= free_bit;
		end else if (state_q == ST_SCAN) begin
			if (sum_full) begin
				blk_s1 <= blk_next;
				lap_q  <= lap_inc;
			end else begin
				word_s1 <= scan_word;
				widx_s1 <= scan_widx;
				sum_s1  <= sum_rdata;
			end
		end
	end

	bba_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORDS),
		.AW    (WA_W)
	) u_map (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	bba_ram #(
		.WIDTH (WPB),
		.DEPTH (MAX_BLOCKS),
		.AW    (BLK_W)
	) u_summary (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

endmodule
